### design/clmr_pkg.sv
package clmr_pkg;

  // frame classes as seen by the back end
  localparam logic [1:0] CLS_SHORT  = 2'd0;
  localparam logic [1:0] CLS_START  = 2'd1;
  localparam logic [1:0] CLS_MIDDLE = 2'd2;
  localparam logic [1:0] CLS_END    = 2'd3;

  // register indexes on the configuration port
  localparam logic [1:0] REG_SHORT_CODE = 2'd0;
  localparam logic [1:0] REG_START_CODE = 2'd1;
  localparam logic [1:0] REG_END_CODE   = 2'd2;
  localparam logic [1:0] REG_BIG_ENDIAN = 2'd3;

  // number of leading header bytes in a start frame
  localparam logic [3:0] HEADER_BYTES = 4'd4;
  localparam logic [3:0] FRAME_BYTES  = 4'd8;

  typedef struct packed {
    logic [11:0] short_code;
    logic [11:0] start_code;
    logic [11:0] end_code;
    logic        big_endian;
  } cfg_t;

  // one classified frame in the queue
  typedef struct packed {
    logic [1:0]  cls;
    logic [7:0]  addr;
    logic [7:0]  cmd;
    logic [11:0] code;
    logic [3:0]  count;
    logic [15:0] hdr_len;
    logic [15:0] hdr_sum;
    logic [63:0] data;
  } item_t;

endpackage

### design/clmr_ram.sv
module clmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/clmr_front.sv
module clmr_front (
  input  logic                clk,
  input  logic                rst,
  input  clmr_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          source_addr,
  input  logic [7:0]          command,
  input  logic [11:0]         type_or_offset,
  input  logic [3:0]          byte_count,
  input  logic [63:0]         frame_bytes,
  output logic                q_valid,
  output clmr_pkg::item_t     q_item,
  input  logic                q_pop
);

  clmr_pkg::item_t entry [2];
  logic            wptr;
  logic            rptr;
  logic [1:0]      fill;

  clmr_pkg::item_t item;
  logic            keep;
  logic            push;
  logic [7:0]      b0, b1, b2, b3;

  // classify the incoming frame
  always_comb begin
    b0 = frame_bytes[7:0];
    b1 = frame_bytes[15:8];
    b2 = frame_bytes[23:16];
    b3 = frame_bytes[31:24];
    item.addr  = source_addr;
    item.cmd   = command;
    item.code  = type_or_offset;
    item.count = (byte_count > clmr_pkg::FRAME_BYTES) ? clmr_pkg::FRAME_BYTES : byte_count;
    item.data  = frame_bytes;
    item.hdr_len = cfg.big_endian ? {b0, b1} : {b1, b0};
    item.hdr_sum = cfg.big_endian ? {b2, b3} : {b3, b2};
    keep     = 1'b1;
    item.cls = clmr_pkg::CLS_SHORT;
    if (type_or_offset == cfg.short_code) begin
      item.cls = clmr_pkg::CLS_SHORT;
    end else if (type_or_offset == cfg.start_code) begin
      item.cls = clmr_pkg::CLS_START;
    end else if (type_or_offset < cfg.short_code) begin
      item.cls = clmr_pkg::CLS_MIDDLE;
    end else if (type_or_offset == cfg.end_code) begin
      item.cls = clmr_pkg::CLS_END;
    end else begin
      keep = 1'b0;
    end
  end

  assign in_stall = (fill == 2'd2);
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = entry[rptr];

  // two-entry request queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (q_pop) begin
        rptr <= ~rptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
    if (push) begin
      entry[wptr] <= item;
    end
  end

endmodule

### design/clmr_back.sv
module clmr_back #(
  parameter int MAX_MSG_BYTES = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  clmr_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            kind,
  output logic [7:0]      out_addr,
  output logic [7:0]      out_command,
  output logic [8:0]      total_length,
  output logic [4:0]      chunk_number,
  output logic [63:0]     chunk_data,
  output logic [3:0]      chunk_valid,
  output logic            last
);

  localparam int AW = $clog2(MAX_MSG_BYTES);
  localparam int LW = $clog2(MAX_MSG_BYTES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRITE = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_OUTW  = 3'd4;

  logic [2:0]  state;

  // session
  logic          sess_open;
  logic [7:0]    sess_cmd;
  logic [7:0]    sess_addr;
  logic [LW-1:0] dlen;
  logic [15:0]   esum;
  logic [15:0]   rsum;
  logic [LW-1:0] brx;

  // current frame
  logic [63:0]   cur_data;
  logic          cur_end;
  logic [3:0]    widx;
  logic [3:0]    wend;

  // delivery
  logic [LW-1:0] rbase;
  logic [4:0]    kcnt;
  logic [3:0]    jcnt;
  logic          pend;
  logic [3:0]    pend_j;
  logic [63:0]   word;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic          take;
  logic          bad_mid;
  logic          bad_end;
  logic          bad_start;
  logic [7:0]    wbyte;
  logic [LW-1:0] remain;
  logic [3:0]    vcnt;
  logic [63:0]   short_mask;

  assign take  = out_valid && !out_stall;
  assign q_pop = (state == S_IDLE) && q_valid && !out_valid;

  // session checks on the queue head
  always_comb begin
    bad_start = (q_item.count < clmr_pkg::HEADER_BYTES) ||
                (q_item.hdr_len > 16'(MAX_MSG_BYTES));
    bad_mid = !sess_open || (q_item.cmd != sess_cmd) || (q_item.addr != sess_addr) ||
              (16'(q_item.code) + 16'(q_item.count) > 16'(dlen)) ||
              (16'(q_item.code) != 16'(brx));
    bad_end = !sess_open || (q_item.cmd != sess_cmd) || (q_item.addr != sess_addr) ||
              (16'(brx) + 16'(q_item.count) != 16'(dlen));
    short_mask = (q_item.count >= clmr_pkg::FRAME_BYTES) ? '1 :
                 ((64'd1 << {q_item.count, 3'b000}) - 64'd1);
  end

  // byte stream and chunk sizing
  always_comb begin
    wbyte     = 8'(cur_data >> {widx, 3'b000});
    remain    = dlen - rbase;
    vcnt      = (remain >= LW'(8)) ? clmr_pkg::FRAME_BYTES : 4'(remain);
    ram_we    = (state == S_WRITE) && (widx != wend);
    ram_waddr = AW'(brx);
    ram_wdata = wbyte;
    ram_raddr = AW'(rbase + LW'(jcnt));
  end

  clmr_ram #(.WIDTH(8), .DEPTH(MAX_MSG_BYTES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sess_open <= 1'b0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (take) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            cur_data <= q_item.data;
            cur_end  <= 1'b0;
            unique case (q_item.cls)
              clmr_pkg::CLS_SHORT: begin
                out_valid    <= 1'b1;
                kind         <= 1'b0;
                out_addr     <= q_item.addr;
                out_command  <= q_item.cmd;
                total_length <= 9'(q_item.count);
                chunk_number <= 5'd0;
                chunk_data   <= q_item.data & short_mask;
                chunk_valid  <= q_item.count;
                last         <= 1'b1;
              end
              clmr_pkg::CLS_START: begin
                if (bad_start) begin
                  sess_open <= 1'b0;
                end else begin
                  sess_open <= 1'b1;
                  sess_cmd  <= q_item.cmd;
                  sess_addr <= q_item.addr;
                  dlen      <= LW'(q_item.hdr_len);
                  esum      <= q_item.hdr_sum;
                  rsum      <= 16'd0;
                  brx       <= '0;
                  widx      <= clmr_pkg::HEADER_BYTES;
                  wend      <= q_item.count;
                  state     <= S_WRITE;
                end
              end
              clmr_pkg::CLS_MIDDLE: begin
                if (bad_mid) begin
                  sess_open <= 1'b0;
                end else begin
                  widx  <= 4'd0;
                  wend  <= q_item.count;
                  state <= S_WRITE;
                end
              end
              default: begin
                if (bad_end) begin
                  sess_open <= 1'b0;
                end else begin
                  cur_end <= 1'b1;
                  widx    <= 4'd0;
                  wend    <= q_item.count;
                  state   <= S_WRITE;
                end
              end
            endcase
          end
        end
        S_WRITE: begin
          if (widx == wend) begin
            state <= cur_end ? S_CHECK : S_IDLE;
          end else begin
            rsum <= rsum + (16'(wbyte) ^ 16'(brx));
            brx  <= brx + LW'(1);
            widx <= widx + 4'd1;
          end
        end
        S_CHECK: begin
          sess_open <= 1'b0;
          rbase     <= '0;
          kcnt      <= 5'd0;
          jcnt      <= 4'd0;
          word      <= 64'd0;
          pend      <= 1'b0;
          state     <= (rsum == esum) ? S_READ : S_IDLE;
        end
        S_READ: begin
          if (jcnt < vcnt) begin
            jcnt   <= jcnt + 4'd1;
            pend   <= 1'b1;
            pend_j <= jcnt;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            word <= word | (64'(ram_rdata) << {pend_j, 3'b000});
          end
          if ((jcnt == vcnt) && !pend) begin
            out_valid    <= 1'b1;
            kind         <= 1'b1;
            out_addr     <= sess_addr;
            out_command  <= sess_cmd;
            total_length <= 9'(dlen);
            chunk_number <= kcnt;
            chunk_data   <= word;
            chunk_valid  <= vcnt;
            last         <= (remain <= LW'(8));
            state        <= S_OUTW;
          end
        end
        S_OUTW: begin
          if (!out_valid) begin
            if (last) begin
              state <= S_IDLE;
            end else begin
              rbase <= rbase + LW'(8);
              kcnt  <= kcnt + 5'd1;
              jcnt  <= 4'd0;
              word  <= 64'd0;
              state <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### design/can_long_message_reassembler.sv
// Reassembles long CAN messages from start, middle and end frames and passes
// short frames straight through. A small front end takes one frame per cycle
// into a two-entry queue (in_stall rises when it is full); unknown codes are
// taken and dropped there. The back end handles one frame at a time and
// writes the payload bytes of a start, middle or end frame into the message
// store one at a time, since it has a single byte-wide write port. A good
// message is then read back one byte per cycle through the store's read
// port, pausing after each chunk of up to 8 bytes while out_stall holds it.
// The store itself needs no clearing after reset.
module can_long_message_reassembler #(
  parameter int MAX_MSG_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  source_addr,
  input  logic [7:0]  command,
  input  logic [11:0] type_or_offset,
  input  logic [3:0]  byte_count,
  input  logic [63:0] frame_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  out_addr,
  output logic [7:0]  out_command,
  output logic [8:0]  total_length,
  output logic [4:0]  chunk_number,
  output logic [63:0] chunk_data,
  output logic [3:0]  chunk_valid,
  output logic        last
);

  clmr_pkg::cfg_t  cfg;
  logic            q_valid;
  clmr_pkg::item_t q_item;
  logic            q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_code <= 12'd4093;
      cfg.start_code <= 12'd4094;
      cfg.end_code   <= 12'd4095;
      cfg.big_endian <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        clmr_pkg::REG_SHORT_CODE: cfg.short_code <= cfg_data;
        clmr_pkg::REG_START_CODE: cfg.start_code <= cfg_data;
        clmr_pkg::REG_END_CODE:   cfg.end_code   <= cfg_data;
        default:                  cfg.big_endian <= cfg_data[0];
      endcase
    end
  end

  clmr_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .source_addr    (source_addr),
    .command        (command),
    .type_or_offset (type_or_offset),
    .byte_count     (byte_count),
    .frame_bytes    (frame_bytes),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  clmr_back #(.MAX_MSG_BYTES(MAX_MSG_BYTES)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .out_addr     (out_addr),
    .out_command  (out_command),
    .total_length (total_length),
    .chunk_number (chunk_number),
    .chunk_data   (chunk_data),
    .chunk_valid  (chunk_valid),
    .last         (last)
  );

endmodule
